FILE: rtl/core/ocs_pkg.sv
// shared types, constants and microcode word layout for the oled frame command streamer
package ocs_pkg;

  // display geometry
  localparam int unsigned Rows     = 64;
  localparam int unsigned RowBytes = 16;
  localparam int unsigned RowW     = (Rows > 1) ? $clog2(Rows) : 1;
  localparam int unsigned ByteW    = (RowBytes > 1) ? $clog2(RowBytes) : 1;

  // microcode addressing
  localparam int unsigned PcW = 5;
  localparam logic [PcW-1:0] InitEntry = 5'd0;
  localparam logic [PcW-1:0] PixEntry  = 5'd26;
  localparam logic [PcW-1:0] LastStep  = 5'd29;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgContrast  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMultiplex = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgOffset    = 2'd2;

  // input item
  typedef struct packed {
    logic       cmd;
    logic [7:0] pixel_byte;
    logic       blank;
    logic       start_frame;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [7:0] spi_byte;
    logic       is_data;
    logic       last;
    logic       frame_done;
  } out_item_t;

  // byte source selected by a microcode step
  typedef enum logic [2:0] {
    SRC_CONST    = 3'd0,
    SRC_CONTRAST = 3'd1,
    SRC_MUX      = 3'd2,
    SRC_OFFSET   = 3'd3,
    SRC_COL_LO   = 3'd4,
    SRC_COL_HI   = 3'd5,
    SRC_PIXEL    = 3'd6
  } src_e;

  // step condition: when false the step emits nothing and jumps to its target
  typedef enum logic [1:0] {
    COND_ALWAYS = 2'd0,
    COND_FRAME  = 2'd1,
    COND_ROW    = 2'd2
  } cond_e;

  // one control word
  typedef struct packed {
    src_e           src;
    logic [7:0]     lit;
    cond_e          cond;
    logic [PcW-1:0] target;
    logic           is_data;
    logic           last;
  } ucode_t;

  // sequencer to datapath controls
  typedef struct packed {
    logic load_item;
    logic advance;
  } dp_ctrl_t;

  // datapath to sequencer status
  typedef struct packed {
    logic frame_first;
    logic row_first;
    logic frame_done;
  } dp_status_t;

endpackage

FILE: rtl/core/oled_frame_command_streamer.sv
// top level: microcode sequencer, output register and datapath of the frame command streamer
// Turns framebuffer byte items into OLED command and data bytes, at most one result item per
// microcode step. Each accepted item starts a short program in a read-only table that runs
// one step per clock while the output does not stall: a pixel item takes three steps
// (mid-row byte) or four (first byte of a row or frame), an init item takes 26 steps. A new
// item is taken the cycle after the last step of the previous one. The result register lets
// the last result wait while the next item enters. Config writes are always ready and take
// effect at once.
module oled_frame_command_streamer import ocs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]         cfg_data_i
);

  logic           busy_q, busy_d;
  logic [PcW-1:0] pc_q, pc_d;
  logic           out_valid_q, out_valid_d;
  out_item_t      out_q, out_d;
  ucode_t         uword;
  dp_ctrl_t       ctrl;
  dp_status_t     status;
  logic [7:0]     dp_byte;
  logic           accept;
  logic           cond_ok;
  logic           slot_free;
  logic           emit;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = busy_q;
  assign accept      = in_valid_i && !busy_q;
  assign slot_free   = !out_valid_q || !out_stall_i;

  ocs_ucode_rom u_rom (
    .pc_i   (pc_q),
    .word_o (uword)
  );

  ocs_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .item_i      (in_data_i),
    .ctrl_i      (ctrl),
    .src_i       (uword.src),
    .lit_i       (uword.lit),
    .byte_o      (dp_byte),
    .status_o    (status)
  );

  // step condition
  always_comb begin
    case (uword.cond)
      COND_ALWAYS: cond_ok = 1'b1;
      COND_FRAME:  cond_ok = status.frame_first;
      COND_ROW:    cond_ok = status.row_first;
      default:     cond_ok = 1'b1;
    endcase
  end

  assign emit           = busy_q && cond_ok && slot_free;
  assign ctrl.load_item = accept;
  assign ctrl.advance   = emit && uword.last && uword.is_data;

  // step counter and jumps
  always_comb begin
    busy_d = busy_q;
    pc_d   = pc_q;
    if (accept) begin
      busy_d = 1'b1;
      pc_d   = in_data_i.cmd ? InitEntry : PixEntry;
    end else if (busy_q) begin
      if (!cond_ok) begin
        pc_d = uword.target;
      end else if (slot_free) begin
        pc_d = pc_q + PcW'(1);
        if (uword.last) begin
          busy_d = 1'b0;
        end
      end
    end
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    if (emit) begin
      out_valid_d      = 1'b1;
      out_d.spi_byte   = dp_byte;
      out_d.is_data    = uword.is_data;
      out_d.last       = uword.last;
      out_d.frame_done = uword.is_data && status.frame_done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pc_q        <= InitEntry;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // an accepted item starts the program
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_q)
    else $error("sequencer not busy after item accept");

  // step counter stays inside the program while running
  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (pc_q <= LastStep))
    else $error("step counter outside microcode program");

  // frame completion only on the final data byte of an item
  a_frame_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!out_data_o.frame_done || (out_data_o.is_data && out_data_o.last)))
    else $error("frame_done on a non-final or command byte");

  // data bytes are always the final result of their item
  a_data_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.is_data) |-> out_data_o.last)
    else $error("data byte not marked last");

endmodule

FILE: rtl/core/ocs_ucode_rom.sv
// microcode table: init command sequence and pixel item program
module ocs_ucode_rom import ocs_pkg::*; (
  input  logic [PcW-1:0] pc_i,
  output ucode_t         word_o
);

  // build one control word
  function automatic ucode_t uw(src_e s, logic [7:0] lit, cond_e c, logic [PcW-1:0] tgt,
                                logic d, logic l);
    ucode_t w;
    w.src     = s;
    w.lit     = lit;
    w.cond    = c;
    w.target  = tgt;
    w.is_data = d;
    w.last    = l;
    return w;
  endfunction

  // program table
  always_comb begin
    unique case (pc_i)
      // init sequence
      5'd0:  word_o = uw(SRC_CONST,    8'hAE, COND_ALWAYS, 5'd0, 1'b0, 1'b0);
      5'd1:  word_o = uw(SRC_CONST,    8'h00, COND_ALWAYS, 5'd0, 1'b0, 1'b0);
      5'd2:  word_o = uw(SRC_CONST,    8'h10, COND_ALWAYS, 5'd0, 1'b0, 1'b0);
      5'd3:  word_o = uw(SRC_CONST,    8'hB0, COND_ALWAYS, 5'd0, 1'b0, 1'b0);
      5'd4:  word_o = uw(SRC_CONST,    8'hDC, COND_ALWAYS, 5'd0, 1'b0, 1'b0);
      5'd5:  word_o = uw(SRC_CONST,    8'h00, COND_ALWAYS, 5'd0, 1'b0, 1'b0);
      5'd6:  word_o = uw(SRC_CONST,    8'h81, COND_ALWAYS, 5'd0, 1'b0, 1'b0);
      5'd7:  word_o = uw(SRC_CONTRAST, 8'h00, COND_ALWAYS, 5'd0, 1'b0, 1'b0);
      5'd8:  word_o = uw(SRC_CONST,    8'h21, COND_ALWAYS, 5'd0, 1'b0, 1'b0);
      5'd9:  word_o = uw(SRC_CONST,    8'hA0, COND_ALWAYS, 5'd0, 1'b0, 1'b0);
      5'd10: word_o = uw(SRC_CONST,    8'hC0, COND_ALWAYS, 5'd0, 1'b0, 1'b0);
      5'd11: word_o = uw(SRC_CONST,    8'hA4, COND_ALWAYS, 5'd0, 1'b0, 1'b0);
      5'd12: word_o = uw(SRC_CONST,    8'hA6, COND_ALWAYS, 5'd0, 1'b0, 1'b0);
      5'd13: word_o = uw(SRC_CONST,    8'hA8, COND_ALWAYS, 5'd0, 1'b0, 1'b0);
      5'd14: word_o = uw(SRC_MUX,      8'h00, COND_ALWAYS, 5'd0, 1'b0, 1'b0);
      5'd15: word_o = uw(SRC_CONST,    8'hD3, COND_ALWAYS, 5'd0, 1'b0, 1'b0);
      5'd16: word_o = uw(SRC_OFFSET,   8'h00, COND_ALWAYS, 5'd0, 1'b0, 1'b0);
      5'd17: word_o = uw(SRC_CONST,    8'hD5, COND_ALWAYS, 5'd0, 1'b0, 1'b0);
      5'd18: word_o = uw(SRC_CONST,    8'h41, COND_ALWAYS, 5'd0, 1'b0, 1'b0);
      5'd19: word_o = uw(SRC_CONST,    8'hD9, COND_ALWAYS, 5'd0, 1'b0, 1'b0);
      5'd20: word_o = uw(SRC_CONST,    8'h22, COND_ALWAYS, 5'd0, 1'b0, 1'b0);
      5'd21: word_o = uw(SRC_CONST,    8'hDB, COND_ALWAYS, 5'd0, 1'b0, 1'b0);
      5'd22: word_o = uw(SRC_CONST,    8'h35, COND_ALWAYS, 5'd0, 1'b0, 1'b0);
      5'd23: word_o = uw(SRC_CONST,    8'hAD, COND_ALWAYS, 5'd0, 1'b0, 1'b0);
      5'd24: word_o = uw(SRC_CONST,    8'h8A, COND_ALWAYS, 5'd0, 1'b0, 1'b0);
      5'd25: word_o = uw(SRC_CONST,    8'hAF, COND_ALWAYS, 5'd0, 1'b0, 1'b1);
      // pixel program: page command, column commands, data byte
      5'd26: word_o = uw(SRC_CONST,    8'hB0, COND_FRAME,  5'd27, 1'b0, 1'b0);
      5'd27: word_o = uw(SRC_COL_LO,   8'h00, COND_ROW,    5'd29, 1'b0, 1'b0);
      5'd28: word_o = uw(SRC_COL_HI,   8'h00, COND_ALWAYS, 5'd0, 1'b0, 1'b0);
      5'd29: word_o = uw(SRC_PIXEL,    8'h00, COND_ALWAYS, 5'd0, 1'b1, 1'b1);
      default: word_o = uw(SRC_CONST,  8'h00, COND_ALWAYS, 5'd0, 1'b0, 1'b1);
    endcase
  end

endmodule

FILE: rtl/core/ocs_datapath.sv
// datapath: config registers, row and byte counters, item register and byte select
module ocs_datapath import ocs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]         cfg_data_i,
  input  in_item_t           item_i,
  input  dp_ctrl_t           ctrl_i,
  input  src_e               src_i,
  input  logic [7:0]         lit_i,
  output logic [7:0]         byte_o,
  output dp_status_t         status_o
);

  localparam logic [RowW-1:0]  LastRowIdx  = RowW'(Rows - 1);
  localparam logic [ByteW-1:0] LastByteIdx = ByteW'(RowBytes - 1);
  localparam logic [7:0]       LastRowCol  = 8'(Rows - 1);

  logic [7:0]       contrast_q, contrast_d;
  logic [6:0]       multiplex_q, multiplex_d;
  logic [6:0]       offset_q, offset_d;
  logic [RowW-1:0]  row_q, row_d;
  logic [ByteW-1:0] byte_q, byte_d;
  logic [7:0]       pixel_q, pixel_d;
  logic             blank_q, blank_d;
  logic [7:0]       col;
  logic [7:0]       flipped;

  // config register writes
  always_comb begin
    contrast_d  = contrast_q;
    multiplex_d = multiplex_q;
    offset_d    = offset_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgContrast:  contrast_d  = cfg_data_i;
        CfgMultiplex: multiplex_d = cfg_data_i[6:0];
        CfgOffset:    offset_d    = cfg_data_i[6:0];
        default:      ;
      endcase
    end
  end

  // row and byte counters, cleared by start_frame, stepped on each data byte
  always_comb begin
    row_d  = row_q;
    byte_d = byte_q;
    if (ctrl_i.load_item && !item_i.cmd && item_i.start_frame) begin
      row_d  = '0;
      byte_d = '0;
    end else if (ctrl_i.advance) begin
      if (byte_q == LastByteIdx) begin
        byte_d = '0;
        row_d  = (row_q == LastRowIdx) ? '0 : row_q + RowW'(1);
      end else begin
        byte_d = byte_q + ByteW'(1);
      end
    end
  end

  // item register
  always_comb begin
    pixel_d = ctrl_i.load_item ? item_i.pixel_byte : pixel_q;
    blank_d = ctrl_i.load_item ? item_i.blank : blank_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      contrast_q  <= 8'd111;
      multiplex_q <= 7'd63;
      offset_q    <= 7'd96;
      row_q       <= '0;
      byte_q      <= '0;
    end else begin
      contrast_q  <= contrast_d;
      multiplex_q <= multiplex_d;
      offset_q    <= offset_d;
      row_q       <= row_d;
      byte_q      <= byte_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pixel_q <= pixel_d;
    blank_q <= blank_d;
  end

  // column address counts down from the last row
  assign col = LastRowCol - 8'(row_q);

  // pixel bit reversal
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      flipped[i] = pixel_q[7-i];
    end
  end

  // byte source select
  always_comb begin
    unique case (src_i)
      SRC_CONST:    byte_o = lit_i;
      SRC_CONTRAST: byte_o = contrast_q;
      SRC_MUX:      byte_o = {1'b0, multiplex_q};
      SRC_OFFSET:   byte_o = {1'b0, offset_q};
      SRC_COL_LO:   byte_o = {4'h0, col[3:0]};
      SRC_COL_HI:   byte_o = 8'h10 + {4'h0, col[7:4]};
      SRC_PIXEL:    byte_o = blank_q ? 8'h00 : flipped;
      default:      byte_o = lit_i;
    endcase
  end

  // position flags for the sequencer
  assign status_o.frame_first = (row_q == '0) && (byte_q == '0);
  assign status_o.row_first   = (byte_q == '0);
  assign status_o.frame_done  = (row_q == LastRowIdx) && (byte_q == LastByteIdx);

endmodule
